// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the pipe RTL.
// Define ASSERT_OFF to compile all checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ASSERT_CHK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CHK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== rtl/bpwm_pkg.sv =====
`timescale 1ns / 1ps

package bpwm_pkg;

    localparam int BUFFER_BYTES_DEF  = 512;
    localparam int PROCESS_SLOTS_DEF = 64;
    localparam int LANES_DEF         = 8;

    // action codes
    localparam logic [2:0] ACT_ALLOC  = 3'd0;
    localparam logic [2:0] ACT_REOPEN = 3'd1;
    localparam logic [2:0] ACT_CLOSE  = 3'd2;
    localparam logic [2:0] ACT_READ   = 3'd3;
    localparam logic [2:0] ACT_WRITE  = 3'd4;
    localparam logic [2:0] ACT_AVAIL  = 3'd5;

    // end select
    localparam logic END_READ  = 1'b0;
    localparam logic END_WRITE = 1'b1;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO      = 3'd1;
    localparam logic [2:0] ST_BLOCK     = 3'd2;
    localparam logic [2:0] ST_NOREADERS = 3'd3;
    localparam logic [2:0] ST_BUSY      = 3'd4;

    // command broadcast to every byte lane for one transfer
    typedef struct packed {
        logic       wr;
        logic       rd;
        logic       clr;
        logic [2:0] wpos;
        logic [2:0] rpos;
        logic [3:0] count;
    } t_lane_cmd;

    // result of one step, held until the lane read data is merged
    typedef struct packed {
        logic        is_read;
        logic [2:0]  rpos;
        logic [2:0]  status;
        logic [3:0]  moved;
        logic [10:0] avail;
        logic [63:0] wake;
    } t_step_res;

endpackage

// ===== rtl/bpwm_lane.sv =====
`timescale 1ns / 1ps

module bpwm_lane
    import bpwm_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
    parameter int LANES        = LANES_DEF,
    parameter int LANE_ID      = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_acc,
    input  t_lane_cmd   i_cmd,
    input  logic [63:0] i_write_data,
    output logic [7:0]  o_rd_byte
);

    // this bank keeps every LANES-th byte of the stream
    localparam int DEPTH = (BUFFER_BYTES + LANES - 1) / LANES;
    localparam int RW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]    mem [DEPTH];
    logic [RW-1:0] r_wrow, n_wrow;
    logic [RW-1:0] r_rrow, n_rrow;
    logic [7:0]    r_rd_byte;
    logic [3:0]    slot_w, slot_r;
    logic          do_wr, do_pop;

    // position of this lane within the transfer, relative to the stream position
    always_comb begin
        if (4'(LANE_ID) >= {1'b0, i_cmd.wpos}) begin
            slot_w = 4'(LANE_ID) - {1'b0, i_cmd.wpos};
        end else begin
            slot_w = 4'(LANE_ID) + 4'(LANES) - {1'b0, i_cmd.wpos};
        end
        if (4'(LANE_ID) >= {1'b0, i_cmd.rpos}) begin
            slot_r = 4'(LANE_ID) - {1'b0, i_cmd.rpos};
        end else begin
            slot_r = 4'(LANE_ID) + 4'(LANES) - {1'b0, i_cmd.rpos};
        end
    end

    assign do_wr  = i_acc && i_cmd.wr && (slot_w < i_cmd.count);
    assign do_pop = i_acc && i_cmd.rd && (slot_r < i_cmd.count);

    assign n_wrow = (r_wrow == RW'(DEPTH - 1)) ? '0 : r_wrow + RW'(1);
    assign n_rrow = (r_rrow == RW'(DEPTH - 1)) ? '0 : r_rrow + RW'(1);

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            mem[r_wrow] <= i_write_data[slot_w[2:0]*8 +: 8];
        end
        if (i_acc) begin
            r_rd_byte <= mem[r_rrow];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrow <= '0;
            r_rrow <= '0;
        end else if (i_acc && i_cmd.clr) begin
            r_wrow <= '0;
            r_rrow <= '0;
        end else begin
            if (do_wr) begin
                r_wrow <= n_wrow;
            end
            if (do_pop) begin
                r_rrow <= n_rrow;
            end
        end
    end

    assign o_rd_byte = r_rd_byte;

endmodule

// ===== rtl/bpwm_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpwm_ctrl
    import bpwm_pkg::*;
#(
    parameter int BUFFER_BYTES  = BUFFER_BYTES_DEF,
    parameter int PROCESS_SLOTS = PROCESS_SLOTS_DEF,
    parameter int LANES         = LANES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_acc,
    input  logic [2:0] i_action,
    input  logic       i_end_sel,
    input  logic [3:0] i_byte_count,
    input  logic [5:0] i_caller_pid,
    input  logic       i_caller_valid,
    output t_lane_cmd  o_cmd,
    output t_step_res  o_res
);

    localparam int FW = $clog2(BUFFER_BYTES + 1);
    localparam int CW = (FW + 1 > 5) ? FW + 1 : 5;
    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int P  = PROCESS_SLOTS;

    logic [FW-1:0] r_fill, n_fill;
    logic [7:0]    r_rrefs, n_rrefs;
    logic [7:0]    r_wrefs, n_wrefs;
    logic [P-1:0]  r_rmask, n_rmask;
    logic [P-1:0]  r_wmask, n_wmask;
    logic [LW-1:0] r_wpos, n_wpos;
    logic [LW-1:0] r_rpos, n_rpos;

    logic [3:0]    req_sat;
    logic [CW-1:0] fill_ext, room, req_ext;
    logic [3:0]    rd_cnt, wr_cnt;
    logic [P-1:0]  pid_bit;
    logic [4:0]    wsum, rsum;
    logic [2:0]    status;
    logic [3:0]    moved;
    logic [10:0]   avail;
    logic [63:0]   wake;
    logic          lane_wr, lane_rd, lane_clr;

    assign req_sat  = (i_byte_count > 4'(LANES)) ? 4'(LANES) : i_byte_count;
    assign fill_ext = CW'(r_fill);
    assign room     = CW'(BUFFER_BYTES) - fill_ext;
    assign req_ext  = CW'(req_sat);
    assign rd_cnt   = (fill_ext < req_ext) ? 4'(fill_ext) : req_sat;
    assign wr_cnt   = (room < req_ext) ? 4'(room) : req_sat;
    assign pid_bit  = (32'(i_caller_pid) < P) ? (P'(1) << i_caller_pid) : '0;
    assign wsum     = 5'(r_wpos) + 5'(wr_cnt);
    assign rsum     = 5'(r_rpos) + 5'(rd_cnt);

    always_comb begin
        n_fill   = r_fill;
        n_rrefs  = r_rrefs;
        n_wrefs  = r_wrefs;
        n_rmask  = r_rmask;
        n_wmask  = r_wmask;
        n_wpos   = r_wpos;
        n_rpos   = r_rpos;
        status   = ST_OK;
        moved    = '0;
        avail    = '0;
        wake     = '0;
        lane_wr  = 1'b0;
        lane_rd  = 1'b0;
        lane_clr = 1'b0;
        case (i_action)
            ACT_ALLOC: begin
                if (r_rrefs == 8'd0 && r_wrefs == 8'd0) begin
                    n_rrefs  = 8'd1;
                    n_wrefs  = 8'd1;
                    n_fill   = '0;
                    n_rmask  = '0;
                    n_wmask  = '0;
                    n_wpos   = '0;
                    n_rpos   = '0;
                    lane_clr = 1'b1;
                end else begin
                    status = ST_BUSY;
                end
            end
            ACT_REOPEN: begin
                if (i_end_sel == END_READ) begin
                    if (r_rrefs != 8'hFF) n_rrefs = r_rrefs + 8'd1;
                end else begin
                    if (r_wrefs != 8'hFF) n_wrefs = r_wrefs + 8'd1;
                end
            end
            ACT_CLOSE: begin
                // when this side's last reference closes, wake the other side, but leave its waiters recorded
                if (i_end_sel == END_READ) begin
                    if (r_rrefs != 8'd0) n_rrefs = r_rrefs - 8'd1;
                    if (r_rrefs <= 8'd1) wake = 64'(r_wmask);
                end else begin
                    if (r_wrefs != 8'd0) n_wrefs = r_wrefs - 8'd1;
                    if (r_wrefs <= 8'd1) wake = 64'(r_rmask);
                end
            end
            ACT_READ: begin
                if (rd_cnt != 4'd0) begin
                    moved   = rd_cnt;
                    lane_rd = 1'b1;
                    n_fill  = r_fill - FW'(rd_cnt);
                    n_rpos  = LW'((rsum >= 5'(LANES)) ? rsum - 5'(LANES) : rsum);
                    if (r_fill == FW'(BUFFER_BYTES)) begin
                        wake    = 64'(r_wmask);
                        n_wmask = '0;
                    end
                end else if (r_wrefs == 8'd0) begin
                    status = ST_ZERO;
                end else if (i_caller_valid) begin
                    n_rmask = r_rmask | pid_bit;
                    status  = ST_BLOCK;
                end else begin
                    status = ST_ZERO;
                end
            end
            ACT_WRITE: begin
                if (r_rrefs == 8'd0) begin
                    status = ST_NOREADERS;
                end else if (wr_cnt != 4'd0) begin
                    moved   = wr_cnt;
                    lane_wr = 1'b1;
                    n_fill  = r_fill + FW'(wr_cnt);
                    n_wpos  = LW'((wsum >= 5'(LANES)) ? wsum - 5'(LANES) : wsum);
                    if (r_fill == '0) begin
                        wake    = 64'(r_rmask);
                        n_rmask = '0;
                    end
                end else if (i_caller_valid) begin
                    n_wmask = r_wmask | pid_bit;
                    status  = ST_BLOCK;
                end else begin
                    status = ST_ZERO;
                end
            end
            ACT_AVAIL: begin
                if (r_fill == '0 && r_wrefs == 8'd0) begin
                    avail = '1;
                end else begin
                    avail = 11'(r_fill);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_rrefs <= '0;
            r_wrefs <= '0;
            r_rmask <= '0;
            r_wmask <= '0;
            r_wpos  <= '0;
            r_rpos  <= '0;
        end else if (i_acc) begin
            r_fill  <= n_fill;
            r_rrefs <= n_rrefs;
            r_wrefs <= n_wrefs;
            r_rmask <= n_rmask;
            r_wmask <= n_wmask;
            r_wpos  <= n_wpos;
            r_rpos  <= n_rpos;
        end
    end

    assign o_cmd.wr    = lane_wr;
    assign o_cmd.rd    = lane_rd;
    assign o_cmd.clr   = lane_clr;
    assign o_cmd.wpos  = 3'(r_wpos);
    assign o_cmd.rpos  = 3'(r_rpos);
    assign o_cmd.count = moved;

    assign o_res.is_read = (i_action == ACT_READ);
    assign o_res.rpos    = 3'(r_rpos);
    assign o_res.status  = status;
    assign o_res.moved   = moved;
    assign o_res.avail   = avail;
    assign o_res.wake    = wake;

    `ASSERT_NEVER(a_fill_cap, i_clk, i_rst_n, r_fill > FW'(BUFFER_BYTES))
    `ASSERT_CHK(a_read_drains, i_clk, i_rst_n,
        (i_acc && i_action == ACT_READ)
            |=> (r_fill == $past(r_fill) - FW'($past(o_res.moved))))
    `ASSERT_CHK(a_write_fills, i_clk, i_rst_n,
        (i_acc && i_action == ACT_WRITE)
            |=> (r_fill == $past(r_fill) + FW'($past(o_res.moved))))

endmodule

// ===== rtl/bpwm_merge.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpwm_merge
    import bpwm_pkg::*;
#(
    parameter int LANES = LANES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  t_step_res              i_res,
    input  logic [LANES-1:0][7:0]  i_lane_bytes,
    input  logic                   i_out_stall,
    output logic                   o_busy,
    output logic                   o_out_valid,
    output logic [2:0]             o_status,
    output logic [3:0]             o_moved_count,
    output logic [63:0]            o_read_data,
    output logic signed [10:0]     o_avail_count,
    output logic [63:0]            o_wake_mask
);

    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

    logic        r_s1_valid;
    t_step_res   r_s1;
    logic        r_out_valid;
    logic [2:0]  r_status;
    logic [3:0]  r_moved;
    logic [63:0] r_rdata;
    logic [10:0] r_avail;
    logic [63:0] r_wake;
    logic [63:0] n_rdata;
    logic        adv;

    // rotate lane bytes back into stream order
    always_comb begin
        logic [4:0]    sum;
        logic [LW-1:0] idx;
        n_rdata = '0;
        for (int j = 0; j < LANES; j++) begin
            sum = 5'(r_s1.rpos) + 5'(j);
            idx = LW'((sum >= 5'(LANES)) ? sum - 5'(LANES) : sum);
            if (r_s1.is_read && 4'(j) < r_s1.moved) begin
                n_rdata[j*8 +: 8] = i_lane_bytes[idx];
            end
        end
    end

    assign adv = r_s1_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1 <= i_res;
        end
        if (adv) begin
            r_status <= r_s1.status;
            r_moved  <= r_s1.moved;
            r_rdata  <= n_rdata;
            r_avail  <= r_s1.avail;
            r_wake   <= r_s1.wake;
        end
    end

    assign o_busy        = r_s1_valid;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_moved_count = r_moved;
    assign o_read_data   = r_rdata;
    assign o_avail_count = $signed(r_avail);
    assign o_wake_mask   = r_wake;

    `ASSERT_CHK(a_no_data_without_bytes, i_clk, i_rst_n, (o_out_valid && o_moved_count == 4'd0) |-> (o_read_data == 64'd0))

endmodule

// ===== rtl/byte_pipe_with_wait_masks.sv =====
`timescale 1ns / 1ps

// Byte pipe with wait masks: one kernel pipe kept as a byte FIFO of
// BUFFER_BYTES bytes, with 8-bit saturating reader/writer reference counts
// and two masks of process ids waiting to read or to write. Each transfer
// on the input channel carries one action (alloc, reopen, close, read,
// write, available query) and yields exactly one result transfer with a
// status, the byte count moved, the read data, the available count and
// the process ids to wake. Each item updates the pointers and writes the
// byte banks at its accept edge; the banks' registered read data is merged
// into the output register once the output is not stalled, and the input
// stalls while that merge stage is occupied, so a new item is accepted only
// once the last has left the merge stage. A finished result waiting in the
// output register does not hold up the next accept. There is no clearing
// pass after reset; the block accepts from the first cycle out of reset.
module byte_pipe_with_wait_masks
    import bpwm_pkg::*;
#(
    parameter int BUFFER_BYTES  = BUFFER_BYTES_DEF,
    parameter int PROCESS_SLOTS = PROCESS_SLOTS_DEF,
    parameter int LANES         = LANES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_action,
    input  logic               i_end_sel,
    input  logic [3:0]         i_byte_count,
    input  logic [63:0]        i_write_data,
    input  logic [5:0]         i_caller_pid,
    input  logic               i_caller_valid,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic [3:0]         o_moved_count,
    output logic [63:0]        o_read_data,
    output logic signed [10:0] o_avail_count,
    output logic [63:0]        o_wake_mask
);

    logic                  acc;
    logic                  busy;
    t_lane_cmd             cmd;
    t_step_res             res;
    logic [LANES-1:0][7:0] lane_bytes;

    // hold off requests while the merge stage has an item, and during reset
    assign o_in_stall = busy || !i_rst_n;
    assign acc        = i_in_valid && !o_in_stall;

    // Pointer, reference-count and wait-mask bookkeeping; decides how many
    // bytes move and broadcasts the lane command.
    bpwm_ctrl #(
        .BUFFER_BYTES  (BUFFER_BYTES),
        .PROCESS_SLOTS (PROCESS_SLOTS),
        .LANES         (LANES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_acc          (acc),
        .i_action       (i_action),
        .i_end_sel      (i_end_sel),
        .i_byte_count   (i_byte_count),
        .i_caller_pid   (i_caller_pid),
        .i_caller_valid (i_caller_valid),
        .o_cmd          (cmd),
        .o_res          (res)
    );

    // One byte bank per lane; byte n of the stream lives in bank n mod LANES,
    // so the bytes of a single transfer always land in distinct banks.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        bpwm_lane #(
            .BUFFER_BYTES (BUFFER_BYTES),
            .LANES        (LANES),
            .LANE_ID      (g)
        ) u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_acc        (acc),
            .i_cmd        (cmd),
            .i_write_data (i_write_data),
            .o_rd_byte    (lane_bytes[g])
        );
    end

    // Rotate lane bytes into stream order and drive the result register.
    bpwm_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (acc),
        .i_res         (res),
        .i_lane_bytes  (lane_bytes),
        .i_out_stall   (i_out_stall),
        .o_busy        (busy),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_moved_count (o_moved_count),
        .o_read_data   (o_read_data),
        .o_avail_count (o_avail_count),
        .o_wake_mask   (o_wake_mask)
    );

endmodule
